// ===== hdl/ncc_coefficient_normalizer_assert.svh =====
// Assertion macros shared by the coefficient normalizer RTL.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef NCC_COEFFICIENT_NORMALIZER_ASSERT_SVH
`define NCC_COEFFICIENT_NORMALIZER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define NCC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define NCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ncc_pkg.sv =====
// Types and constants of the coefficient normalizer.
// No dependencies; used by every module of the block except the queue.
`timescale 1ns / 1ps

package ncc_pkg;

    typedef struct packed {
        logic [27:0] corr_raw;
        logic [29:0] sum_top_left;
        logic [29:0] sum_top_right;
        logic [29:0] sum_bottom_left;
        logic [29:0] sum_bottom_right;
        logic [37:0] sq_top_left;
        logic [37:0] sq_top_right;
        logic [37:0] sq_bottom_left;
        logic [37:0] sq_bottom_right;
    } in_t;

    typedef struct packed {
        logic signed [15:0] coefficient;
        logic [1:0]         outcome;
    } out_t;

    typedef struct packed {
        logic [23:0] template_mean;
        logic [31:0] inv_area;
        logic [20:0] template_norm;
        logic        flat_template;
    } cfg_t;

    // Work passed from the front end to the back end.
    typedef struct packed {
        logic signed [59:0] num;
        logic [61:0]        var_q;
        logic               den_zero;
    } mid_t;

    localparam logic [1:0] REG_TEMPLATE_MEAN = 2'd0;
    localparam logic [1:0] REG_INV_AREA      = 2'd1;
    localparam logic [1:0] REG_TEMPLATE_NORM = 2'd2;
    localparam logic [1:0] REG_FLAT_TEMPLATE = 2'd3;

    localparam logic [1:0] OUTCOME_DIVIDED = 2'd0;
    localparam logic [1:0] OUTCOME_CLAMPED = 2'd1;
    localparam logic [1:0] OUTCOME_ZEROED  = 2'd2;
    localparam logic [1:0] OUTCOME_FLAT    = 2'd3;

    localparam logic [31:0]        INV_AREA_RESET = 32'h8000_0000;
    localparam logic signed [15:0] ONE_Q14        = 16'sd16384;
    localparam logic signed [15:0] MINUS_ONE_Q14  = -16'sd16384;
    // Variance floor of one half in Q.22.
    localparam logic [21:0]        VAR_FLOOR      = 22'd2097152;

endpackage

// ===== hdl/ncc_coefficient_normalizer.sv =====
// Top level of the normalized cross-correlation coefficient block.
// Depends on ncc_pkg, ncc_front, ncc_fifo and ncc_back.
`timescale 1ns / 1ps
//
//  Channel   Signals                          Transfer when
//  --------  -------------------------------  -------------------------
//  input     push, full, item (in_t)          push high and full low
//  result    pop, empty, result (out_t)       pop high and empty low
//  config    cfg_write, cfg_index, cfg_data   cfg_write high
//
// One item is taken per cycle and one result is delivered per cycle when
// neither side stalls. The path from push to result runs through five front
// stages, the queue, 31 square root stages, the denominator multiply and
// the division stages ahead of the output register.
// The front end runs while the queue has room; the back end runs while the
// output register is empty or being popped, so each side stalls on its own.
// Reset clears the valid bits and puts the registers at their reset values.

module ncc_coefficient_normalizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  ncc_pkg::in_t  item,
    input  logic          pop,
    output logic          empty,
    output ncc_pkg::out_t result,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    ncc_pkg::cfg_t cfg_reg;

    logic          f_en;
    logic          f_valid;
    ncc_pkg::mid_t f_data;
    logic          q_full;
    logic          q_nonempty;
    logic          q_pop;
    logic          q_wr;
    logic [$bits(ncc_pkg::mid_t)-1:0] q_rd_data;

    // The user must write registers only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.template_mean <= '0;
            cfg_reg.inv_area      <= ncc_pkg::INV_AREA_RESET;
            cfg_reg.template_norm <= '0;
            cfg_reg.flat_template <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ncc_pkg::REG_TEMPLATE_MEAN: cfg_reg.template_mean <= cfg_data[23:0];
                ncc_pkg::REG_INV_AREA:      cfg_reg.inv_area      <= cfg_data;
                ncc_pkg::REG_TEMPLATE_NORM: cfg_reg.template_norm <= cfg_data[20:0];
                ncc_pkg::REG_FLAT_TEMPLATE: cfg_reg.flat_template <= cfg_data[0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The front pipeline advances whenever the queue can take its last stage.
    assign f_en = !q_full;
    assign full = !f_en;
    assign q_wr = f_valid && f_en;

    ncc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (f_en),
        .in_valid  (push && !full),
        .item      (item),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    ncc_fifo #(
        .WIDTH ($bits(ncc_pkg::mid_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (f_data),
        .rd_en    (q_pop),
        .rd_data  (q_rd_data),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    ncc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_nonempty),
        .q_data  (ncc_pkg::mid_t'(q_rd_data)),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ===== hdl/ncc_fifo.sv =====
// Short register queue that decouples the front end from the back end.
// Depends on the assertion header only; the payload is a plain vector.
`timescale 1ns / 1ps
`include "ncc_coefficient_normalizer_assert.svh"

module ncc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data  = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);

    `NCC_ASSERT_NEXT(a_fifo_count_up, wr_en && !rd_en, count_reg == $past(count_reg) + CNT_W'(1), "queue count did not advance on a lone write")
    `NCC_ASSERT_ALWAYS(a_fifo_no_underflow, !rd_en || count_reg != '0, "queue read while empty")
    `NCC_ASSERT_ALWAYS(a_fifo_no_overflow, !wr_en || !full, "queue written while full")

endmodule

// ===== hdl/ncc_front.sv =====
// Front end: window sums, numerator and clamped window variance, five stages.
// Depends on ncc_pkg for the item, configuration and queue entry types.
`timescale 1ns / 1ps

module ncc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ncc_pkg::in_t  item,
    input  ncc_pkg::cfg_t cfg,
    output logic          out_valid,
    output ncc_pkg::mid_t out_data
);

    logic [4:0] valid_reg;

    // Stage 1: corner sums.
    logic [27:0]        s1_corr_reg;
    logic signed [31:0] s1_sum_reg;
    logic signed [39:0] s1_sq_reg;
    logic [31:0]        sum_next;
    logic [39:0]        sq_next;

    // Stage 2: products with the mean and the squared sum.
    logic [27:0]        s2_corr_reg;
    logic signed [39:0] s2_sq_reg;
    logic signed [56:0] s2_prod_reg;
    logic [61:0]        s2_s2_reg;
    logic signed [56:0] prod_next;
    logic [30:0]        abs_next;

    // Stage 3: numerator and split product with the inverse area.
    logic signed [59:0] s3_num_reg;
    logic signed [39:0] s3_sq_reg;
    logic [63:0]        s3_plo_reg;
    logic [61:0]        s3_phi_reg;

    // Stage 4: full product.
    logic signed [59:0] s4_num_reg;
    logic signed [39:0] s4_sq_reg;
    logic [93:0]        s4_prod_reg;

    // Stage 5: variance and threshold.
    logic signed [59:0] s5_num_reg;
    logic [61:0]        s5_var_reg;
    logic [21:0]        s5_thr_reg;
    logic               s5_qpos_reg;
    logic               qpos;
    logic [63:0]        qs;
    logic [63:0]        m_lo;
    logic [61:0]        var_next;
    logic [41:0]        q5;
    logic [21:0]        thr_next;

    always_comb
    begin
        sum_next = {2'b00, item.sum_top_left} - {2'b00, item.sum_top_right}
                 - {2'b00, item.sum_bottom_left} + {2'b00, item.sum_bottom_right};
        sq_next  = {2'b00, item.sq_top_left} - {2'b00, item.sq_top_right}
                 - {2'b00, item.sq_bottom_left} + {2'b00, item.sq_bottom_right};
        prod_next = s1_sum_reg * $signed({1'b0, cfg.template_mean});
        abs_next  = s1_sum_reg[31] ? 31'(-s1_sum_reg) : s1_sum_reg[30:0];
    end

    always_comb
    begin
        qpos = !s4_sq_reg[39] && (s4_sq_reg != '0);
        qs   = {3'b000, s4_sq_reg[38:0], 22'd0};
        m_lo = s4_prod_reg[72:9];
        if (!qpos || (|s4_prod_reg[93:73]) || (m_lo >= qs))
        begin
            var_next = '0;
        end
        else
        begin
            var_next = 62'(qs - m_lo - 64'(|s4_prod_reg[8:0]));
        end
        q5 = {1'b0, s4_sq_reg[38:0], 2'b00} + {3'b000, s4_sq_reg[38:0]};
        thr_next = (q5 < {20'd0, ncc_pkg::VAR_FLOOR}) ? q5[21:0] : ncc_pkg::VAR_FLOOR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_corr_reg <= item.corr_raw;
            s1_sum_reg  <= sum_next;
            s1_sq_reg   <= sq_next;

            s2_corr_reg <= s1_corr_reg;
            s2_sq_reg   <= s1_sq_reg;
            s2_prod_reg <= prod_next;
            s2_s2_reg   <= {31'd0, abs_next} * {31'd0, abs_next};

            s3_num_reg  <= $signed({13'd0, s2_corr_reg, 19'd0}) - $signed({s2_prod_reg, 3'b000});
            s3_sq_reg   <= s2_sq_reg;
            s3_plo_reg  <= {32'd0, s2_s2_reg[31:0]} * {32'd0, cfg.inv_area};
            s3_phi_reg  <= {32'd0, s2_s2_reg[61:32]} * {30'd0, cfg.inv_area};

            s4_num_reg  <= s3_num_reg;
            s4_sq_reg   <= s3_sq_reg;
            s4_prod_reg <= {30'd0, s3_plo_reg} + {s3_phi_reg, 32'd0};

            s5_num_reg  <= s4_num_reg;
            s5_var_reg  <= var_next;
            s5_thr_reg  <= thr_next;
            s5_qpos_reg <= qpos;
        end
    end

    assign out_valid         = valid_reg[4];
    assign out_data.num      = s5_num_reg;
    assign out_data.var_q    = s5_var_reg;
    assign out_data.den_zero = !s5_qpos_reg || (s5_var_reg <= {40'd0, s5_thr_reg});

endmodule

// ===== hdl/ncc_back.sv =====
// Back end: pipelined square root, denominator, restoring division, output register.
// Depends on ncc_pkg and on the assertion header.
`timescale 1ns / 1ps
`include "ncc_coefficient_normalizer_assert.svh"

module ncc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ncc_pkg::mid_t q_data,
    output logic          q_pop,
    input  ncc_pkg::cfg_t cfg,
    input  logic          pop,
    output logic          empty,
    output ncc_pkg::out_t result
);

    localparam int SQ_N = 31;
    localparam int DV_N = 15;

    logic b_en;

    logic [SQ_N:0] sq_valid_reg;
    logic [63:0]   sq_rem_reg  [SQ_N+1];
    logic [30:0]   sq_root_reg [SQ_N+1];
    logic [59:0]   sq_mag_reg  [SQ_N+1];
    logic          sq_neg_reg  [SQ_N+1];
    logic          sq_dz_reg   [SQ_N+1];

    logic        md_valid_reg;
    logic [51:0] md_den_reg;
    logic [59:0] md_mag_reg;
    logic        md_neg_reg;

    logic [DV_N:0] dv_valid_reg;
    logic [51:0]   dv_r_reg      [DV_N+1];
    logic [14:0]   dv_q_reg      [DV_N+1];
    logic [51:0]   dv_den_reg    [DV_N+1];
    logic          dv_small_reg  [DV_N+1];
    logic          dv_margin_reg [DV_N+1];
    logic          dv_neg_reg    [DV_N+1];

    logic          out_valid_reg;
    ncc_pkg::out_t out_reg, out_next;

    logic          small_next;
    logic          margin_next;
    logic [62:0]   den9;
    logic [14:0]   cmag;
    logic [15:0]   cround;

    assign b_en  = !out_valid_reg || pop;
    assign q_pop = b_en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= '0;
            md_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (b_en)
        begin
            sq_valid_reg  <= {sq_valid_reg[SQ_N-1:0], q_valid};
            md_valid_reg  <= sq_valid_reg[SQ_N];
            dv_valid_reg  <= {dv_valid_reg[DV_N-1:0], md_valid_reg};
            out_valid_reg <= dv_valid_reg[DV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            sq_rem_reg[0]  <= {2'b00, q_data.var_q};
            sq_root_reg[0] <= '0;
            sq_mag_reg[0]  <= q_data.num[59] ? 60'(-q_data.num) : 60'(q_data.num);
            sq_neg_reg[0]  <= q_data.num[59];
            sq_dz_reg[0]   <= q_data.den_zero;
        end
    end

    // One root bit per stage, most significant first.
    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        localparam int K = SQ_N - 1 - i;
        logic [63:0] trial;
        logic        take;

        assign trial = ({33'd0, sq_root_reg[i]} << (K + 1)) | (64'd1 << (2 * K));
        assign take  = (sq_rem_reg[i] >= trial);

        always_ff @(posedge clk)
        begin
            if (b_en)
            begin
                sq_rem_reg[i+1]  <= take ? sq_rem_reg[i] - trial : sq_rem_reg[i];
                sq_root_reg[i+1] <= take ? (sq_root_reg[i] | (31'd1 << K)) : sq_root_reg[i];
                sq_mag_reg[i+1]  <= sq_mag_reg[i];
                sq_neg_reg[i+1]  <= sq_neg_reg[i];
                sq_dz_reg[i+1]   <= sq_dz_reg[i];
            end
        end
    end

    always_comb
    begin
        small_next  = (md_mag_reg < {8'd0, md_den_reg});
        den9        = {8'd0, md_den_reg, 3'b000} + {11'd0, md_den_reg};
        margin_next = ({md_mag_reg, 3'b000} < den9);
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            md_den_reg <= sq_dz_reg[SQ_N] ? '0
                        : {21'd0, sq_root_reg[SQ_N]} * {31'd0, cfg.template_norm};
            md_mag_reg <= sq_mag_reg[SQ_N];
            md_neg_reg <= sq_neg_reg[SQ_N];

            dv_r_reg[0]      <= small_next ? md_mag_reg[51:0] : '0;
            dv_q_reg[0]      <= '0;
            dv_den_reg[0]    <= md_den_reg;
            dv_small_reg[0]  <= small_next;
            dv_margin_reg[0] <= margin_next;
            dv_neg_reg[0]    <= md_neg_reg;
        end
    end

    // One quotient bit per stage.
    for (genvar j = 0; j < DV_N; j++)
    begin : g_div
        logic [52:0] r2;
        logic        ge;

        assign r2 = {dv_r_reg[j], 1'b0};
        assign ge = (r2 >= {1'b0, dv_den_reg[j]});

        always_ff @(posedge clk)
        begin
            if (b_en)
            begin
                dv_r_reg[j+1]      <= 52'(ge ? r2 - {1'b0, dv_den_reg[j]} : r2);
                dv_q_reg[j+1]      <= {dv_q_reg[j][13:0], ge};
                dv_den_reg[j+1]    <= dv_den_reg[j];
                dv_small_reg[j+1]  <= dv_small_reg[j];
                dv_margin_reg[j+1] <= dv_margin_reg[j];
                dv_neg_reg[j+1]    <= dv_neg_reg[j];
            end
        end
    end

    always_comb
    begin
        cround = ({1'b0, dv_q_reg[DV_N]} + 16'd1) >> 1;
        cmag   = cround[14:0];
        if (cfg.flat_template)
        begin
            out_next.coefficient = ncc_pkg::ONE_Q14;
            out_next.outcome     = ncc_pkg::OUTCOME_FLAT;
        end
        else if (dv_small_reg[DV_N])
        begin
            out_next.coefficient = dv_neg_reg[DV_N] ? -$signed({1'b0, cmag})
                                                    : $signed({1'b0, cmag});
            out_next.outcome     = ncc_pkg::OUTCOME_DIVIDED;
        end
        else if (dv_margin_reg[DV_N])
        begin
            out_next.coefficient = dv_neg_reg[DV_N] ? ncc_pkg::MINUS_ONE_Q14
                                                    : ncc_pkg::ONE_Q14;
            out_next.outcome     = ncc_pkg::OUTCOME_CLAMPED;
        end
        else
        begin
            out_next.coefficient = '0;
            out_next.outcome     = ncc_pkg::OUTCOME_ZEROED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            out_reg <= out_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    `NCC_ASSERT_ALWAYS(a_back_divided_range, !out_valid_reg || out_reg.outcome != ncc_pkg::OUTCOME_DIVIDED || (out_reg.coefficient <= ncc_pkg::ONE_Q14 && out_reg.coefficient >= ncc_pkg::MINUS_ONE_Q14), "divided coefficient beyond one")
    `NCC_ASSERT_ALWAYS(a_back_zeroed_value, !out_valid_reg || out_reg.outcome != ncc_pkg::OUTCOME_ZEROED || out_reg.coefficient == '0, "zeroed outcome with nonzero coefficient")
    `NCC_ASSERT_NEXT(a_back_hold, out_valid_reg && !pop, out_valid_reg && out_reg == $past(out_reg), "waiting result changed before its transfer")

endmodule

// ===== tb/ncc_checker.sv =====
// Checker for the coefficient normalizer: tracks the registers, predicts each result and
// compares it with what the block delivers. Depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          full,
    input  ncc_pkg::in_t  item,
    input  logic          pop,
    input  logic          empty,
    input  ncc_pkg::out_t result,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output int            errors,
    output int            pending
);

    ncc_pkg::cfg_t cfg;
    ncc_pkg::out_t coef_queue[$];
    int            err_count = 0;

    assign pending = coef_queue.size();
    assign errors  = err_count;

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic ncc_pkg::out_t predict_coefficient(ncc_pkg::in_t it, ncc_pkg::cfg_t c);
        longint        s;
        longint        q;
        longint        num;
        logic [63:0]   mag;
        logic [63:0]   s_abs;
        logic [127:0]  prod;
        logic [63:0]   m_lo;
        logic [63:0]   qs;
        logic [63:0]   wvar;
        logic [63:0]   thr;
        logic [63:0]   den;
        logic [63:0]   rem_div;
        logic [63:0]   quo;
        logic [63:0]   coef;
        logic [1:0]    oc;
        ncc_pkg::out_t o;
        if (c.flat_template)
        begin
            o.coefficient = ncc_pkg::ONE_Q14;
            o.outcome = ncc_pkg::OUTCOME_FLAT;
            return o;
        end
        s = longint'(it.sum_top_left) - longint'(it.sum_top_right)
          - longint'(it.sum_bottom_left) + longint'(it.sum_bottom_right);
        q = longint'(it.sq_top_left) - longint'(it.sq_top_right)
          - longint'(it.sq_bottom_left) + longint'(it.sq_bottom_right);
        num = (longint'(it.corr_raw) <<< 19) - s * longint'(c.template_mean) * 8;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        s_abs = (s < 0) ? 64'(-s) : 64'(s);
        // Exact product of S squared and the Q1.31 reciprocal, floored to Q.22.
        prod = 128'(s_abs * s_abs) * 128'(c.inv_area);
        m_lo = prod[72:9];
        if (q <= 0 || prod[127:73] != 0)
            wvar = 0;
        else
        begin
            qs = 64'(q) << 22;
            if (m_lo >= qs)
                wvar = 0;
            else
                wvar = qs - m_lo - ((prod[8:0] != 0) ? 64'd1 : 64'd0);
        end
        thr = 64'd1 << 21;
        if (q > 0 && 64'(q) * 5 < thr)
            thr = 64'(q) * 5;
        if (q <= 0 || wvar <= thr)
            den = 0;
        else
            den = floor_sqrt(wvar) * 64'(c.template_norm);
        if (mag < den)
        begin
            rem_div = mag;
            quo = 0;
            for (int i = 0; i < 15; i++)
            begin
                rem_div = rem_div << 1;
                quo = quo << 1;
                if (rem_div >= den)
                begin
                    rem_div = rem_div - den;
                    quo = quo | 1;
                end
            end
            coef = (quo + 1) >> 1;
            oc = ncc_pkg::OUTCOME_DIVIDED;
        end
        else if (mag * 8 < den * 9)
        begin
            coef = 64'd16384;
            oc = ncc_pkg::OUTCOME_CLAMPED;
        end
        else
        begin
            coef = 0;
            oc = ncc_pkg::OUTCOME_ZEROED;
        end
        if (num < 0)
            coef = -coef;
        o.coefficient = coef[15:0];
        o.outcome = oc;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ncc_pkg::out_t exp_r;
        if (!rst_n)
        begin
            cfg.template_mean <= '0;
            cfg.inv_area <= ncc_pkg::INV_AREA_RESET;
            cfg.template_norm <= '0;
            cfg.flat_template <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ncc_pkg::REG_TEMPLATE_MEAN: cfg.template_mean <= cfg_data[23:0];
                    ncc_pkg::REG_INV_AREA:      cfg.inv_area <= cfg_data;
                    ncc_pkg::REG_TEMPLATE_NORM: cfg.template_norm <= cfg_data[20:0];
                    ncc_pkg::REG_FLAT_TEMPLATE: cfg.flat_template <= cfg_data[0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (coef_queue.size() == 0)
                begin
                    $error("result transfer with nothing expected: coefficient %0d outcome %0d",
                           result.coefficient, result.outcome);
                    err_count++;
                end
                else
                begin
                    exp_r = coef_queue.pop_front();
                    if (result.coefficient !== exp_r.coefficient)
                    begin
                        $error("coefficient: expected %0d, actual %0d",
                               exp_r.coefficient, result.coefficient);
                        err_count++;
                    end
                    if (result.outcome !== exp_r.outcome)
                    begin
                        $error("outcome: expected %0d, actual %0d",
                               exp_r.outcome, result.outcome);
                        err_count++;
                    end
                end
            end
            if (push && !full)
                coef_queue = {coef_queue, predict_coefficient(item, cfg)};
        end
    end

endmodule

// ===== tb/ncc_coefficient_normalizer_tb.sv =====
// Testbench top for the coefficient normalizer: drives items, configuration and result stalls.
// Depends on ncc_pkg, ncc_coefficient_normalizer and ncc_checker.
`timescale 1ns / 1ps

module ncc_coefficient_normalizer_tb;

    logic          clk;
    logic          rst_n;
    logic          push;
    logic          full;
    ncc_pkg::in_t  item;
    logic          pop;
    logic          empty;
    ncc_pkg::out_t result;
    logic          cfg_write;
    logic [1:0]    cfg_index;
    logic [31:0]   cfg_data;
    int            errors;
    int            pending;

    // Window area of the current setting, used to shape realistic windows.
    int          area;

    ncc_coefficient_normalizer uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .pop(pop), .empty(empty), .result(result),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ncc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .pop(pop), .empty(empty), .result(result),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legitimate run.
    initial
    begin
        #30ms;
        $display("Some tests failed");
        $finish;
    end

    // The receiver switches between stall patterns at random: always ready,
    // a coin toss, or mostly stalled so the queue backs up into the input side.
    initial
    begin
        int mode;
        pop = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(50, 300))
            begin
                @(negedge clk);
                case (mode)
                    0: pop = 1'b1;
                    1: pop = 1'($urandom_range(0, 1));
                    default: pop = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Holds one item on the input until the transfer happens. Push stays high on return so
    // that a following item in the same burst goes out on the next cycle.
    task automatic send_item(ncc_pkg::in_t it);
        item = it;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // A random pause between bursts; zero length keeps push high.
    task automatic burst_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Registers change only once the block has drained, plus a margin for its pipeline.
    task automatic wait_idle();
        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic apply_setting(logic [23:0] mean, int n, logic [20:0] norm, bit flat);
        wait_idle();
        area = n;
        write_reg(ncc_pkg::REG_TEMPLATE_MEAN, 32'(mean));
        write_reg(ncc_pkg::REG_INV_AREA, 32'((64'd1 << 31) / n));
        write_reg(ncc_pkg::REG_TEMPLATE_NORM, 32'(norm));
        write_reg(ncc_pkg::REG_FLAT_TEMPLATE, 32'(flat));
    endtask

    function automatic ncc_pkg::in_t random_noise();
        ncc_pkg::in_t it;
        it.corr_raw = 28'({$urandom(), $urandom()});
        it.sum_top_left = 30'($urandom());
        it.sum_top_right = 30'($urandom());
        it.sum_bottom_left = 30'($urandom());
        it.sum_bottom_right = 30'($urandom());
        it.sq_top_left = 38'({$urandom(), $urandom()});
        it.sq_top_right = 38'({$urandom(), $urandom()});
        it.sq_bottom_left = 38'({$urandom(), $urandom()});
        it.sq_bottom_right = 38'({$urandom(), $urandom()});
        return it;
    endfunction

    // A window whose sums and correlation hang together: pixel mean and spread are drawn,
    // the correlation follows from a random coefficient that sometimes exceeds one so the
    // clamp and zero paths are reached. The sums are spread over random corner offsets.
    function automatic ncc_pkg::in_t random_window(logic [23:0] mean_q, logic [20:0] norm_q);
        ncc_pkg::in_t it;
        real     wm;
        real     ws;
        real     rho;
        real     tstd;
        real     corr;
        longint  s;
        longint  q;
        longint  a;
        longint  b;
        longint  c;
        wm = $urandom_range(0, 255);
        ws = ($urandom_range(0, 7) == 0) ? 0.0 : $urandom_range(0, 12000) / 100.0;
        rho = ($urandom_range(0, 2600) - 1300.0) / 1000.0;
        tstd = norm_q / (256.0 * $sqrt(area));
        s = longint'(area * wm);
        q = longint'(area * (wm * wm + ws * ws));
        corr = area * (mean_q / 65536.0) * wm + rho * area * tstd * ws;
        if (corr < 0.0)
            corr = 0.0;
        if (corr > 266342400.0)
            corr = 266342400.0;
        it.corr_raw = 28'(longint'(corr));
        a = longint'($urandom_range(0, 1 << 28));
        b = longint'($urandom_range(0, 1 << 28));
        c = longint'($urandom_range(0, 1 << 28));
        it.sum_top_left = 30'(a);
        it.sum_top_right = 30'(b);
        it.sum_bottom_left = 30'(c);
        it.sum_bottom_right = 30'(s - a + b + c);
        if (s - a + b + c < 0)
            it.sum_top_left = '0;
        a = {$urandom_range(0, 31), $urandom()};
        b = {$urandom_range(0, 31), $urandom()};
        c = {$urandom_range(0, 31), $urandom()};
        it.sq_top_left = 38'(a);
        it.sq_top_right = 38'(b);
        it.sq_bottom_left = 38'(c);
        it.sq_bottom_right = 38'(q - a + b + c);
        if (q - a + b + c < 0)
            it.sq_top_left = '0;
        return it;
    endfunction

    initial
    begin
        ncc_pkg::in_t it;
        logic [23:0]  mean_q;
        logic [20:0]  norm_q;
        int           n;
        push = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = ncc_pkg::REG_TEMPLATE_MEAN;
        cfg_data = '0;
        area = 1;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: zero norm, so every result comes out zeroed.
        send_item(random_window(24'd0, 21'd0));
        send_item(random_noise());

        // Directed part at a mid setting: field extremes, near-zero variance, negative
        // window sums, and the flat template override.
        apply_setting(24'd128 << 16, 64, 21'(40 * 8 * 256), 1'b0);
        send_item('0);
        send_item('1);
        it = '0;
        it.corr_raw = 28'd266342400;
        send_item(it);
        it.sum_bottom_right = 30'd1069547520;
        it.sq_bottom_right = 38'd272734617600;
        send_item(it);
        it = '0;
        it.sum_top_right = 30'd1069547520;
        it.sq_bottom_right = 38'd1000;
        send_item(it);
        it = '0;
        it.sq_top_left = 38'd5;
        send_item(it);
        it = '0;
        it.sum_bottom_right = 30'(64 * 100);
        it.sq_bottom_right = 38'(64 * 10000);
        it.corr_raw = 28'(64 * 128 * 100);
        send_item(it);
        it.sq_bottom_right = 38'(64 * 10000 + 1);
        send_item(it);
        repeat (12) send_item(random_window(24'd128 << 16, 21'(40 * 8 * 256)));
        apply_setting(24'd128 << 16, 64, 21'(40 * 8 * 256), 1'b1);
        send_item(random_window(24'd0, 21'd0));
        send_item('1);

        // Random phases over a range of settings, extremes included.
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: begin mean_q = 24'd0;        n = 4096; norm_q = 21'd2088960; end
                1: begin mean_q = 24'd16711680; n = 1;    norm_q = 21'd0;       end
                2: begin mean_q = 24'd16711680; n = 4096; norm_q = 21'd2088960; end
                3: begin mean_q = 24'd100 << 16; n = 16;  norm_q = 21'(30 * 4 * 256); end
                4: begin mean_q = 24'd0;        n = 1;    norm_q = 21'd1;       end
                default:
                begin
                    mean_q = 24'($urandom_range(0, 16711680));
                    n = $urandom_range(1, 4096);
                    norm_q = 21'($urandom_range(0, 2088960));
                end
            endcase
            apply_setting(mean_q, n, norm_q, ph == 8);
            repeat (100)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(random_noise());
                else
                    send_item(random_window(mean_q, norm_q));
                if ($urandom_range(0, 2) == 0)
                    burst_gap();
            end
        end

        // Drain, then allow the pipeline to settle before the verdict.
        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ncc_pkg.sv
hdl/ncc_fifo.sv
hdl/ncc_front.sv
hdl/ncc_back.sv
hdl/ncc_coefficient_normalizer.sv
tb/ncc_checker.sv
tb/ncc_coefficient_normalizer_tb.sv
